// ===== rtl/tgb_pkg.sv =====
// Shared types and constants for the tiled glyph blitter.
// Used by tgb_front, tgb_back and tiled_glyph_blitter; no dependencies.
package tgb_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W = 3;

  localparam logic [1:0] MODE_GLYPH   = 2'd0;
  localparam logic [1:0] MODE_NEWLINE = 2'd1;
  localparam logic [1:0] MODE_HOME    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_TILE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AREA_WIDTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MARGIN_L   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MARGIN_T   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_OFS   = 3'd4;

  localparam logic [7:0] BYTE_ONES = 8'b11111111;
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef enum logic [1:0] {
    CMD_GLYPH,
    CMD_NEWLINE,
    CMD_HOME
  } cmd_kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TILE,
    S_READ,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] glyph_width;
    logic [4:0] glyph_height;
    logic       two_planes;
    logic [7:0] plane_low_bits;
    logic [7:0] plane_high_bits;
    logic       glyph_end;
  } in_t;

  typedef struct packed {
    logic [7:0] tile_index;
    logic [2:0] tile_row;
    logic [7:0] plane_low_out;
    logic [7:0] plane_high_out;
    logic       run_last;
  } out_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [4:0] width;
    logic [4:0] height;
    logic       two_planes;
    logic [7:0] plane_low;
    logic [7:0] plane_high;
    logic       glyph_end;
  } cmd_t;

  typedef struct packed {
    logic [7:0] first_tile;
    logic [5:0] area_width_tiles;
    logic [3:0] margin_left;
    logic [3:0] margin_top;
    logic [3:0] line_start_offset;
  } cfg_t;

endpackage

// ===== rtl/tgb_front.sv =====
// Front end: accepts input words, decodes the mode, clamps the glyph width
// and queues commands for the back end. Depends on tgb_pkg.
module tgb_front #(
  parameter int MAX_GLYPH_SIDE = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tgb_pkg::in_t  in_data,
  input  logic          back_clearing,
  output logic          cmd_valid,
  output tgb_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  localparam int PTR_W = (tgb_pkg::QUEUE_DEPTH > 1) ? $clog2(tgb_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tgb_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(tgb_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(tgb_pkg::QUEUE_DEPTH);
  localparam logic [4:0] MAX_W = 5'(MAX_GLYPH_SIDE);

  tgb_pkg::cmd_t     queue_r [tgb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  tgb_pkg::cmd_t     cmd_nxt;
  logic              keep;
  logic              push;

  always_comb begin
    cmd_nxt.kind       = tgb_pkg::CMD_GLYPH;
    keep               = 1'b1;
    unique case (in_data.mode)
      tgb_pkg::MODE_GLYPH:   cmd_nxt.kind = tgb_pkg::CMD_GLYPH;
      tgb_pkg::MODE_NEWLINE: cmd_nxt.kind = tgb_pkg::CMD_NEWLINE;
      tgb_pkg::MODE_HOME:    cmd_nxt.kind = tgb_pkg::CMD_HOME;
      default:               keep = 1'b0;
    endcase
    if (in_data.glyph_width == 5'd0) begin
      cmd_nxt.width = 5'd1;
    end else if (in_data.glyph_width > MAX_W) begin
      cmd_nxt.width = MAX_W;
    end else begin
      cmd_nxt.width = in_data.glyph_width;
    end
    cmd_nxt.height     = in_data.glyph_height;
    cmd_nxt.two_planes = in_data.two_planes;
    cmd_nxt.plane_low  = in_data.plane_low_bits;
    cmd_nxt.plane_high = in_data.plane_high_bits;
    cmd_nxt.glyph_end  = in_data.glyph_end;
  end

  assign in_stall  = (count_r == FULL_CNT) || back_clearing;
  assign push      = in_valid && !in_stall && keep;
  assign cmd_valid = (count_r != '0);
  assign cmd       = queue_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !cmd_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && cmd_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (count_r != '0))
    else $error("command popped from an empty queue");

endmodule

// ===== rtl/tgb_back.sv =====
// Back end: owns the cursor, the source counters and the tile canvas memory,
// and cuts glyph bytes into runs written back by read-modify-write. Depends on tgb_pkg.
module tgb_back #(
  parameter int TILE_COUNT = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tgb_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  input  tgb_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          back_clearing,
  output logic          out_valid,
  input  logic          out_stall,
  output tgb_pkg::out_t out_data
);

  localparam int TW    = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
  localparam int AW    = TW + 3;
  localparam int DEPTH = TILE_COUNT * 8;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  function automatic logic [7:0] tile_wrap(input logic [7:0] t);
    logic [7:0] r;
    logic       ge_k;
    logic       ge_k1;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      ge_k  = (k * TILE_COUNT <= 255) && (int'(t) >= k * TILE_COUNT);
      ge_k1 = ((k + 1) * TILE_COUNT <= 255) && (int'(t) >= (k + 1) * TILE_COUNT);
      if (ge_k && !ge_k1) begin
        r = r | (t - 8'(k * TILE_COUNT));
      end
    end
    return r;
  endfunction

  tgb_pkg::state_t state_r, state_nxt;

  logic [15:0]   canvas_mem [DEPTH];
  logic [15:0]   rd_r;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] slot_r;
  logic [AW-1:0] slot_nxt;
  logic [TW-1:0] tile_mod;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  logic [7:0] cursor_col_r;
  logic [7:0] cursor_line_r;
  logic [4:0] source_col_r;
  logic [4:0] source_line_r;

  logic [4:0] width_r;
  logic [4:0] height_r;
  logic       two_r;
  logic       last_r;
  logic [7:0] b0_r;
  logic [7:0] b1_r;
  logic [3:0] remain_r;
  logic [3:0] take_r;
  logic [2:0] bx_r;
  logic [2:0] by_r;
  logic [7:0] tile_r;

  logic          out_valid_r;
  tgb_pkg::out_t out_r;

  logic       out_free;
  logic       mem_we;
  logic       mem_re;
  logic       out_load;
  logic       run_done;
  logic       clear_we;

  logic [7:0] x;
  logic [7:0] y;
  logic [4:0] span_left;
  logic [3:0] tile_left;
  logic [3:0] take_nxt;
  logic [7:0] tile_nxt;
  logic [7:0] mask;
  logic [7:0] a0;
  logic [7:0] a1;
  logic [7:0] p0;
  logic [7:0] p1;
  logic [4:0] sc_sum;
  logic [7:0] line_start;
  logic [7:0] cc_adv;
  logic       wrap;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tgb_pkg::S_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) state_nxt = tgb_pkg::S_IDLE;
      end
      tgb_pkg::S_IDLE: begin
        if (cmd_valid && cmd.kind == tgb_pkg::CMD_GLYPH) state_nxt = tgb_pkg::S_TILE;
      end
      tgb_pkg::S_TILE: state_nxt = tgb_pkg::S_READ;
      tgb_pkg::S_READ: state_nxt = tgb_pkg::S_WRITE;
      tgb_pkg::S_WRITE: begin
        if (out_free) begin
          state_nxt = (remain_r == take_r) ? tgb_pkg::S_IDLE : tgb_pkg::S_TILE;
        end
      end
      default: state_nxt = tgb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop       = (state_r == tgb_pkg::S_IDLE) && cmd_valid;
    clear_we      = (state_r == tgb_pkg::S_CLEAR);
    back_clearing = (state_r == tgb_pkg::S_CLEAR);
    mem_re        = (state_r == tgb_pkg::S_READ);
    out_load      = (state_r == tgb_pkg::S_WRITE) && out_free;
    mem_we        = clear_we || out_load;
    run_done      = out_load && (remain_r == take_r);
  end

  // Run geometry for the step that computes the tile.
  always_comb begin
    x         = cursor_col_r + {3'b000, source_col_r};
    y         = cursor_line_r + {3'b000, source_line_r};
    span_left = width_r - source_col_r;
    tile_left = tgb_pkg::BYTE_BITS - {1'b0, x[2:0]};
    take_nxt  = remain_r;
    if ({1'b0, tile_left} < 5'(take_nxt)) take_nxt = tile_left;
    if (span_left < 5'(take_nxt)) take_nxt = span_left[3:0];
    tile_nxt  = 8'(cfg.first_tile + {3'b000, x[7:3]}
                   + 11'(y[7:3]) * 11'(cfg.area_width_tiles));
  end

  assign tile_mod = TW'(tile_wrap(tile_r));
  assign slot_nxt = {tile_mod, by_r};

  always_comb begin
    mask    = tgb_pkg::BYTE_ONES << (tgb_pkg::BYTE_BITS - take_r);
    a0      = b0_r & mask;
    a1      = two_r ? (b1_r & mask) : a0;
    p0      = rd_r[7:0] | (a0 >> bx_r);
    p1      = rd_r[15:8] | (a1 >> bx_r);
    wr_addr = clear_we ? clr_addr_r : slot_r;
    wr_data = clear_we ? 16'h0000 : {p1, p0};
  end

  always_comb begin
    sc_sum     = source_col_r + {1'b0, take_r};
    line_start = {4'h0, cfg.margin_left} + {4'h0, cfg.line_start_offset};
    cc_adv     = cursor_col_r + {3'b000, width_r};
    wrap       = ({1'b0, cc_adv} + {5'b00000, cfg.margin_left})
                 >= {cfg.area_width_tiles, 3'b000};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      canvas_mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_r <= canvas_mem[slot_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == tgb_pkg::CMD_GLYPH) begin
      width_r  <= cmd.width;
      height_r <= cmd.height;
      two_r    <= cmd.two_planes;
      last_r   <= cmd.glyph_end;
    end
    if (state_r == tgb_pkg::S_TILE) begin
      take_r <= take_nxt;
      bx_r   <= x[2:0];
      by_r   <= y[2:0];
      tile_r <= tile_nxt;
    end
    if (mem_re) begin
      slot_r <= slot_nxt;
    end
    if (out_load) begin
      out_r.tile_index     <= tile_r;
      out_r.tile_row       <= by_r;
      out_r.plane_low_out  <= p0;
      out_r.plane_high_out <= p1;
      out_r.run_last       <= (remain_r == take_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tgb_pkg::S_CLEAR;
      clr_addr_r    <= '0;
      cursor_col_r  <= '0;
      cursor_line_r <= '0;
      source_col_r  <= '0;
      source_line_r <= '0;
      remain_r      <= '0;
      b0_r          <= '0;
      b1_r          <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clear_we) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
      if (cmd_pop) begin
        case (cmd.kind)
          tgb_pkg::CMD_NEWLINE: begin
            cursor_col_r  <= line_start;
            cursor_line_r <= cursor_line_r + {3'b000, cmd.height};
            source_col_r  <= '0;
            source_line_r <= '0;
          end
          tgb_pkg::CMD_HOME: begin
            cursor_col_r  <= line_start;
            cursor_line_r <= {4'h0, cfg.margin_top};
            source_col_r  <= '0;
            source_line_r <= '0;
          end
          default: begin
            remain_r <= tgb_pkg::BYTE_BITS;
            b0_r     <= cmd.plane_low;
            b1_r     <= cmd.plane_high;
            if (source_col_r >= cmd.width) begin
              source_col_r  <= '0;
              source_line_r <= source_line_r + 1'b1;
            end
          end
        endcase
      end
      if (out_load) begin
        remain_r <= remain_r - take_r;
        b0_r     <= b0_r << take_r;
        b1_r     <= b1_r << take_r;
        if (run_done && last_r) begin
          source_col_r  <= '0;
          source_line_r <= '0;
          if (wrap) begin
            cursor_col_r  <= line_start;
            cursor_line_r <= cursor_line_r + {3'b000, height_r};
          end else begin
            cursor_col_r <= cc_adv;
          end
        end else if (sc_sum >= width_r) begin
          source_col_r  <= '0;
          source_line_r <= source_line_r + 1'b1;
        end else begin
          source_col_r <= sc_sum;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    back_clearing |-> !cmd_pop)
    else $error("command taken during the canvas clearing pass");

  a_take_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tgb_pkg::S_READ) |-> (take_r != 4'd0 && take_r <= remain_r))
    else $error("run length outside the bits left in the byte");

  a_source_inside_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tgb_pkg::S_TILE) |-> (source_col_r < width_r))
    else $error("source column beyond the glyph width");

  a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tgb_pkg::S_WRITE))
    else $error("result word appeared outside a canvas write");

endmodule

// ===== rtl/tiled_glyph_blitter.sv =====
// Top level of the tiled glyph blitter: configuration registers, front end
// and back end. Depends on tgb_pkg, tgb_front and tgb_back.
//
// Channel  Direction  Handshake           Word
// in       input      in_valid/in_stall   tgb_pkg::in_t
// out      output     out_valid/out_stall tgb_pkg::out_t
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A glyph byte is cut into runs (one to eight): each run computes its tile,
// reads the canvas row through the registered memory port, then writes it back.
// New line and cursor home are handled as they leave the queue; mode 3 words are dropped on entry.
// After reset a clearing pass zeroes all TILE_COUNT * 8 canvas rows while
// in_stall is held high; configuration writes are taken at any time.
// A stalled result waits in the output register; a two-entry queue keeps accepting.
module tiled_glyph_blitter #(
  parameter int TILE_COUNT     = 256,
  parameter int MAX_GLYPH_SIDE = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tgb_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tgb_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tgb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);

  tgb_pkg::cfg_t cfg_r;
  tgb_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;
  logic          back_clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_tile        <= 8'd0;
      cfg_r.area_width_tiles  <= 6'd20;
      cfg_r.margin_left       <= 4'd0;
      cfg_r.margin_top        <= 4'd0;
      cfg_r.line_start_offset <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tgb_pkg::REG_FIRST_TILE: cfg_r.first_tile        <= cfg_data;
        tgb_pkg::REG_AREA_WIDTH: cfg_r.area_width_tiles  <= cfg_data[5:0];
        tgb_pkg::REG_MARGIN_L:   cfg_r.margin_left       <= cfg_data[3:0];
        tgb_pkg::REG_MARGIN_T:   cfg_r.margin_top        <= cfg_data[3:0];
        tgb_pkg::REG_LINE_OFS:   cfg_r.line_start_offset <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  tgb_front #(
    .MAX_GLYPH_SIDE(MAX_GLYPH_SIDE)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .back_clearing (back_clearing),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  tgb_back #(
    .TILE_COUNT(TILE_COUNT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .back_clearing (back_clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule
